[sv/tked_pkg.sv]
// Shared constants, types and key lookup functions for the escape key decoder.
`default_nettype none
package tked_pkg;

   localparam int ByteW = 8;
   localparam int CodeW = 11;
   localparam int ModW  = 6;
   localparam int PhaseW = 3;

   localparam logic [ByteW-1:0] CharEsc     = 8'h1B;
   localparam logic [ByteW-1:0] CharBracket = 8'h5B;
   localparam logic [ByteW-1:0] CharOne     = 8'h31;
   localparam logic [ByteW-1:0] CharSemi    = 8'h3B;

   localparam logic [CodeW-1:0] CodeUp    = 11'd1001;
   localparam logic [CodeW-1:0] CodeDown  = 11'd1002;
   localparam logic [CodeW-1:0] CodeRight = 11'd1003;
   localparam logic [CodeW-1:0] CodeLeft  = 11'd1004;
   localparam logic [CodeW-1:0] CodeHome  = 11'd1005;
   localparam logic [CodeW-1:0] CodeEnd   = 11'd1006;
   localparam logic [CodeW-1:0] CodeNone  = 11'd0;

   typedef struct packed {
      logic              emit;
      logic [CodeW-1:0]  code;
      logic [PhaseW-1:0] phase;
      logic [ModW-1:0]   mod_offset;
   } tked_step_type;

   // Final letter to key code; CodeNone when the byte is no key letter.
   function automatic logic [CodeW-1:0] letter_code(input logic [ByteW-1:0] b);
      logic [CodeW-1:0] c;
      case (b)
         8'h41:   c = CodeUp;
         8'h42:   c = CodeDown;
         8'h43:   c = CodeRight;
         8'h44:   c = CodeLeft;
         8'h48:   c = CodeHome;
         8'h46:   c = CodeEnd;
         default: c = CodeNone;
      endcase
      return c;
   endfunction

   function automatic logic [ModW-1:0] modifier_of(input logic [ByteW-1:0] b);
      logic [ModW-1:0] m;
      case (b)
         8'h32:   m = 6'd20;
         8'h33:   m = 6'd30;
         8'h34:   m = 6'd40;
         8'h35:   m = 6'd50;
         default: m = 6'd0;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

[sv/terminal_key_escape_decoder_core.sv]
// A result appears on rsp_ in the cycle after the byte that completes it.
// Throughput: one byte per cycle while req_stall is low; the sequence state
// updates in the cycle of the transfer and the key code sits in a single
// output register. req_stall rises only while that output register is full
// and stalled. Reset (synchronous, active high) returns to idle with no
// sequence in progress, a zero modifier and no result pending.
`default_nettype none
module terminal_key_escape_decoder_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [tked_pkg::ByteW-1:0]  req_rx_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [tked_pkg::CodeW-1:0]       rsp_key_code
);
   import tked_pkg::*;

   logic [PhaseW-1:0] phase_ff;
   logic [ModW-1:0]   mod_ff;
   logic              valid_ff;
   logic              valid_in;
   logic [CodeW-1:0]  code_ff;
   logic              slot_free;
   logic              accept;
   tked_step_type     step;

   tked_decode u_decode (
      .phase      (phase_ff),
      .mod_offset (mod_ff),
      .rx_byte    (req_rx_byte),
      .step       (step)
   );

   assign slot_free = !valid_ff || !rsp_stall;
   assign req_stall = !slot_free;
   assign accept    = req_valid && slot_free;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = accept && step.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         mod_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            phase_ff <= step.phase;
            mod_ff   <= step.mod_offset;
         end
      end
   end

   // load the key code only on a transfer that yields a result
   always_ff @(posedge clock) begin
      if (accept && step.emit) begin
         code_ff <= step.code;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_key_code = code_ff;

endmodule
`default_nettype wire

[sv/tked_decode.sv]
// Next-state and key code logic for one received byte.
`default_nettype none
module tked_decode (
   input  wire logic [tked_pkg::PhaseW-1:0] phase,
   input  wire logic [tked_pkg::ModW-1:0]   mod_offset,
   input  wire logic [tked_pkg::ByteW-1:0]  rx_byte,
   output tked_pkg::tked_step_type          step
);
   import tked_pkg::*;

   localparam logic [PhaseW-1:0] PhIdle    = 3'd0;
   localparam logic [PhaseW-1:0] PhEsc     = 3'd1;
   localparam logic [PhaseW-1:0] PhBracket = 3'd2;
   localparam logic [PhaseW-1:0] PhOne     = 3'd3;
   localparam logic [PhaseW-1:0] PhSemi    = 3'd4;
   localparam logic [PhaseW-1:0] PhMod     = 3'd5;

   logic [CodeW-1:0] letter;
   logic [CodeW-1:0] raw;

   assign letter = letter_code(rx_byte);
   assign raw    = {{(CodeW-ByteW){1'b0}}, rx_byte};

   always_comb begin
      step.emit       = 1'b1;
      step.code       = raw;
      step.phase      = PhIdle;
      step.mod_offset = mod_offset;
      unique case (phase)
         PhEsc: begin
            if (rx_byte == CharBracket) begin
               step.emit  = 1'b0;
               step.phase = PhBracket;
            end
         end
         PhBracket: begin
            if (rx_byte == CharOne) begin
               step.emit  = 1'b0;
               step.phase = PhOne;
            end else if (letter != CodeNone) begin
               step.code = letter;
            end
         end
         PhOne: begin
            if (rx_byte == CharSemi) begin
               step.emit  = 1'b0;
               step.phase = PhSemi;
            end
         end
         PhSemi: begin
            // take any byte as the modifier
            step.emit       = 1'b0;
            step.phase      = PhMod;
            step.mod_offset = modifier_of(rx_byte);
         end
         PhMod: begin
            if (letter != CodeNone) begin
               step.code = letter + {{(CodeW-ModW){1'b0}}, mod_offset};
            end
            step.mod_offset = '0;
         end
         default: begin
            // idle, and the unused codes behave as idle
            if (rx_byte == CharEsc) begin
               step.emit  = 1'b0;
               step.phase = PhEsc;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

[sv/tked_checker.sv]
// Port-level checks for the escape key decoder, bound to the top level.
`default_nettype none
module tked_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [tked_pkg::CodeW-1:0] rsp_key_code
);
   import tked_pkg::*;

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_code))
      else $error("stalled result changed");

   // a full, stalled output must push back on the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input not stalled while output is blocked");

   // key codes are raw bytes or cursor keys plus a modifier
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_code <= 11'd255) ||
                    (rsp_key_code >= CodeUp && rsp_key_code <= 11'd1056))
      else $error("key code out of range");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // with the output free, the input is never stalled
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind terminal_key_escape_decoder_core tked_checker u_tked_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_key_code (rsp_key_code)
);
`default_nettype wire

[test/tb_terminal_key_escape_decoder_core.sv]
// Self-checking testbench for the terminal key escape decoder core.
`timescale 1ns / 100ps
module tb_terminal_key_escape_decoder_core;
   import tked_pkg::*;

   localparam int QuietLimit = 1000;
   localparam int LongHold   = 80;

   localparam logic [ByteW-1:0] KeyUp    = 8'h41;
   localparam logic [ByteW-1:0] KeyDown  = 8'h42;
   localparam logic [ByteW-1:0] KeyRight = 8'h43;
   localparam logic [ByteW-1:0] KeyLeft  = 8'h44;
   localparam logic [ByteW-1:0] KeyHome  = 8'h48;
   localparam logic [ByteW-1:0] KeyEnd   = 8'h46;
   localparam logic [ByteW-1:0] ModTwo   = 8'h32;
   localparam logic [ByteW-1:0] ModThree = 8'h33;
   localparam logic [ByteW-1:0] ModFour  = 8'h34;
   localparam logic [ByteW-1:0] ModFive  = 8'h35;

   typedef enum logic [PhaseW-1:0] {
      SeqIdle, SeqEsc, SeqBracket, SeqOne, SeqSemi, SeqMod
   } seq_phase_type;

   class key_code_board_type;
      logic [CodeW-1:0] expected_codes[$];
      seq_phase_type    phase;
      logic [ModW-1:0]  mod_offset;
      int unsigned      errors;

      function new();
         phase      = SeqIdle;
         mod_offset = '0;
         errors     = 0;
      endfunction

      function logic [CodeW-1:0] key_for(input logic [ByteW-1:0] b);
         case (b)
            KeyUp:    return CodeUp;
            KeyDown:  return CodeDown;
            KeyRight: return CodeRight;
            KeyLeft:  return CodeLeft;
            KeyHome:  return CodeHome;
            KeyEnd:   return CodeEnd;
            default:  return CodeNone;
         endcase
      endfunction

      // Advance the sequence state by one byte and queue any key code it yields.
      function void note_byte(input logic [ByteW-1:0] b);
         logic [CodeW-1:0] k;
         k = key_for(b);
         case (phase)
            SeqEsc: begin
               if (b == CharBracket) begin
                  phase = SeqBracket;
               end else begin
                  phase = SeqIdle;
                  expected_codes.push_back(CodeW'(b));
               end
            end
            SeqBracket: begin
               if (b == CharOne) begin
                  phase = SeqOne;
               end else begin
                  phase = SeqIdle;
                  expected_codes.push_back((k != CodeNone) ? k : CodeW'(b));
               end
            end
            SeqOne: begin
               if (b == CharSemi) begin
                  phase = SeqSemi;
               end else begin
                  phase = SeqIdle;
                  expected_codes.push_back(CodeW'(b));
               end
            end
            SeqSemi: begin
               case (b)
                  ModTwo:   mod_offset = 6'd20;
                  ModThree: mod_offset = 6'd30;
                  ModFour:  mod_offset = 6'd40;
                  ModFive:  mod_offset = 6'd50;
                  default:  mod_offset = 6'd0;
               endcase
               phase = SeqMod;
            end
            SeqMod: begin
               phase = SeqIdle;
               expected_codes.push_back((k != CodeNone) ? CodeW'(k + CodeW'(mod_offset))
                                                        : CodeW'(b));
               mod_offset = '0;
            end
            default: begin
               if (b == CharEsc) begin
                  phase = SeqEsc;
               end else begin
                  phase = SeqIdle;
                  expected_codes.push_back(CodeW'(b));
               end
            end
         endcase
      endfunction

      function void check_code(input logic [CodeW-1:0] code);
         logic [CodeW-1:0] want;
         if (expected_codes.size() == 0) begin
            if (errors < 10) $display("unexpected key code %0d", code);
            errors++;
         end else begin
            want = expected_codes.pop_front();
            if (code !== want) begin
               if (errors < 10) $display("key code mismatch: expected %0d, got %0d", want, code);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [ByteW-1:0]    req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [CodeW-1:0]    rsp_key_code;

   key_code_board_type board;
   int unsigned   bytes_sent  = 0;
   int unsigned   quiet_cycles = 0;
   bit            gaps_on     = 1'b1;
   bit            held_long   = 1'b0;

   terminal_key_escape_decoder_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_key_code (rsp_key_code)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Score every transfer on both channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) board.check_code(rsp_key_code);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no transfer for %0d cycles", QuietLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold to back the block up.
   initial begin
      forever begin
         @(posedge clock);
         if (!held_long && bytes_sent >= 300) begin
            held_long = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LongHold) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic drive_byte(input logic [ByteW-1:0] b);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Send the first cut bytes of ESC [ 1 ; mod, then the final byte.
   task automatic send_seq(input int unsigned cut, input logic [ByteW-1:0] mod_b,
                           input logic [ByteW-1:0] last_b);
      logic [ByteW-1:0] prefix [5];
      prefix[0] = CharEsc;
      prefix[1] = CharBracket;
      prefix[2] = CharOne;
      prefix[3] = CharSemi;
      prefix[4] = mod_b;
      for (int i = 0; i < cut; i++) drive_byte(prefix[i]);
      drive_byte(last_b);
   endtask

   function automatic logic [ByteW-1:0] pick_letter();
      case ($urandom_range(0, 5))
         0:       return KeyUp;
         1:       return KeyDown;
         2:       return KeyRight;
         3:       return KeyLeft;
         4:       return KeyHome;
         default: return KeyEnd;
      endcase
   endfunction

   function automatic logic [ByteW-1:0] pick_modifier();
      case ($urandom_range(0, 3))
         0:       return ModTwo;
         1:       return ModThree;
         2:       return ModFour;
         default: return ModFive;
      endcase
   endfunction

   initial begin
      int unsigned      cut;
      logic [ByteW-1:0] mod_b;
      logic [ByteW-1:0] last_b;

      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // plain bytes at the range ends
      send_seq(0, 8'h00, 8'h00);
      send_seq(0, 8'h00, 8'hFF);
      send_seq(0, 8'h00, KeyUp);
      // every cursor key without a modifier
      send_seq(2, 8'h00, KeyUp);
      send_seq(2, 8'h00, KeyDown);
      send_seq(2, 8'h00, KeyRight);
      send_seq(2, 8'h00, KeyLeft);
      send_seq(2, 8'h00, KeyHome);
      send_seq(2, 8'h00, KeyEnd);
      // every modifier, plus unknown ones that give no offset
      send_seq(5, ModTwo, KeyUp);
      send_seq(5, ModThree, KeyDown);
      send_seq(5, ModFour, KeyRight);
      send_seq(5, ModFive, KeyLeft);
      send_seq(5, 8'h39, KeyHome);
      send_seq(5, 8'hFF, KeyEnd);
      send_seq(5, ModFive, 8'h7A);
      send_seq(5, ModTwo, CharEsc);
      // break-offs at each position, a second ESC among them
      send_seq(1, 8'h00, CharEsc);
      send_seq(1, 8'h00, 8'h80);
      send_seq(2, 8'h00, CharEsc);
      send_seq(2, 8'h00, 8'h7F);
      send_seq(3, 8'h00, ModTwo);
      // ESC taken as the modifier byte, then the letter
      send_seq(4, 8'h00, CharEsc);
      send_seq(0, 8'h00, KeyUp);

      while (bytes_sent < 750) begin
         if (bytes_sent >= 650) gaps_on = 1'b0;
         if ($urandom_range(0, 9) < 7) begin
            cut    = $urandom_range(0, 1) ? 5 : 2;
            mod_b  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_modifier();
            last_b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : pick_letter();
         end else begin
            cut    = $urandom_range(0, 5);
            mod_b  = 8'($urandom);
            last_b = ($urandom_range(0, 2) == 0) ? CharEsc : 8'($urandom);
         end
         send_seq(cut, mod_b, last_b);
      end
      req_valid <= 1'b0;

      while (board.expected_codes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (board.expected_codes.size() != 0) board.errors++;
      if (board.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
